[hdl/mtgd_pkg.sv]
// Package for the multi-tap gesture detector.
// Holds the transaction payload types, field widths and register indexes.
// No dependencies.
package mtgd_pkg;

    localparam int TIME_WIDTH   = 32;
    localparam int SAMPLE_WIDTH = 8;
    localparam int CFG_WIDTH    = 16;
    localparam int CFG_ADDR_W   = 2;
    localparam int NUM_AXES     = 3;
    localparam int COUNT_WIDTH  = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_TAP_WINDOW  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DOWN_LIMIT_Z = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DOWN_LIMIT_Y = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DOWN_HOLD   = 2'd3;

    localparam int SRC_SIGN   = 3;
    localparam int SRC_SINGLE = 4;
    localparam int SRC_ACTIVE = 6;

    localparam logic [15:0] TAP_WINDOW_RESET = 16'd350;
    localparam logic [15:0] DOWN_HOLD_RESET  = 16'd200;
    localparam logic [7:0]  DOWN_LIMIT_RESET = 8'sd8;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [TIME_WIDTH-1:0]          now_ms;
        logic signed [SAMPLE_WIDTH-1:0] sample_y;
        logic signed [SAMPLE_WIDTH-1:0] sample_z;
        logic                           pin_level;
        logic [7:0]                     click_source;
    } gesture_in_t;

    typedef struct packed {
        logic [3:0] x_taps;
        logic [2:0] y_taps;
        logic [1:0] z_taps;
        logic       down_event;
    } gesture_out_t;

endpackage

[hdl/multi_tap_gesture_detector.sv]
// Multi-tap and face-down gesture detector, top level.
// Depends on mtgd_pkg for payload types, widths and register indexes.
//
//  channel   signals                          direction
//  input     in_valid, in_ready, in_data      poll transaction in
//  output    out_valid, out_ready, out_data   one result per poll out
//  config    cfg_write, cfg_addr, cfg_data    register write, no wait
//
// A poll is latched in the input register, evaluated against the gesture state and
// written to the result register once that register is empty or being taken. One
// poll is accepted every cycle while the output side takes results. When the result
// register is full and not taken, a poll waiting in the input register holds and
// in_ready drops. Reset clears the gesture state, both valid flags and the
// configuration registers to their defaults.
module multi_tap_gesture_detector
    import mtgd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  gesture_in_t           in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output gesture_out_t          out_data,
    input  logic                  cfg_write,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_WIDTH-1:0]  cfg_data
);

    logic [15:0]       tap_window_reg;
    logic signed [7:0] down_limit_z_reg;
    logic signed [7:0] down_limit_y_reg;
    logic [15:0]       down_hold_reg;

    logic        s1_valid_reg;
    gesture_in_t s1_data_reg;
    logic         out_valid_reg;
    gesture_out_t out_data_reg;

    logic                   pin_seen_reg, pin_seen_next;
    logic                   is_down_reg, is_down_next;
    logic [TIME_WIDTH-1:0]  down_start_reg, down_start_next;
    logic [TIME_WIDTH-1:0]  last_tap_reg [NUM_AXES];
    logic [TIME_WIDTH-1:0]  last_tap_next [NUM_AXES];
    logic [COUNT_WIDTH-1:0] tap_count_reg [NUM_AXES];
    logic [COUNT_WIDTH-1:0] tap_count_next [NUM_AXES];

    logic         advance;
    gesture_out_t result;
    logic         face_down;
    logic         fire;
    logic         tap_ok;
    logic [NUM_AXES-1:0]    closing;
    logic [COUNT_WIDTH-1:0] closed_count [NUM_AXES];
    logic [TIME_WIDTH-1:0]  tap_age [NUM_AXES];
    logic [TIME_WIDTH-1:0]  down_age;

    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_window_reg   <= TAP_WINDOW_RESET;
            down_limit_z_reg <= DOWN_LIMIT_RESET;
            down_limit_y_reg <= DOWN_LIMIT_RESET;
            down_hold_reg    <= DOWN_HOLD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_addr)
                REG_TAP_WINDOW:   tap_window_reg   <= cfg_data;
                REG_DOWN_LIMIT_Z: down_limit_z_reg <= cfg_data[7:0];
                REG_DOWN_LIMIT_Y: down_limit_y_reg <= cfg_data[7:0];
                REG_DOWN_HOLD:    down_hold_reg    <= cfg_data;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            tap_age[i]      = s1_data_reg.now_ms - last_tap_reg[i];
            closing[i]      = (tap_count_reg[i] != '0) &&
                              (tap_age[i] > {{(TIME_WIDTH-16){1'b0}}, tap_window_reg});
            closed_count[i] = closing[i] ? '0 : tap_count_reg[i];
        end

        result = '0;
        if (closing[0])
        begin
            result.x_taps = (tap_count_reg[0] >= 8'd10) ? 4'd10 : tap_count_reg[0][3:0];
        end
        if (closing[1] && tap_count_reg[1] <= 8'd4)
        begin
            result.y_taps = tap_count_reg[1][2:0];
        end
        if (closing[2] && tap_count_reg[2] <= 8'd2)
        begin
            result.z_taps = tap_count_reg[2][1:0];
        end

        face_down = ($signed(s1_data_reg.sample_z) <= down_limit_z_reg) &&
                    ($signed(s1_data_reg.sample_y) <= down_limit_y_reg);
        down_age  = s1_data_reg.now_ms - down_start_reg;
        fire      = face_down && is_down_reg &&
                    (down_age > {{(TIME_WIDTH-16){1'b0}}, down_hold_reg});

        is_down_next    = face_down;
        down_start_next = (face_down && !is_down_reg) ? s1_data_reg.now_ms : down_start_reg;

        pin_seen_next = pin_seen_reg;
        tap_ok        = s1_data_reg.click_source[SRC_ACTIVE] &&
                        s1_data_reg.click_source[SRC_SIGN] &&
                        s1_data_reg.click_source[SRC_SINGLE];
        for (int i = 0; i < NUM_AXES; i++)
        begin
            last_tap_next[i]  = last_tap_reg[i];
            tap_count_next[i] = closed_count[i];
        end

        if (fire)
        begin
            result            = '0;
            result.down_event = 1'b1;
        end
        else if (s1_data_reg.pin_level)
        begin
            if (!pin_seen_reg)
            begin
                pin_seen_next = 1'b1;
                if (tap_ok)
                begin
                    for (int i = 0; i < NUM_AXES; i++)
                    begin
                        if (s1_data_reg.click_source[i])
                        begin
                            last_tap_next[i] = s1_data_reg.now_ms;
                            if (closed_count[i] != COUNT_MAX)
                            begin
                                tap_count_next[i] = closed_count[i] + 1'b1;
                            end
                        end
                    end
                end
            end
        end
        else
        begin
            pin_seen_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            pin_seen_reg   <= 1'b0;
            is_down_reg    <= 1'b0;
            down_start_reg <= '0;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                last_tap_reg[i]  <= '0;
                tap_count_reg[i] <= '0;
            end
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg  <= 1'b1;
                pin_seen_reg   <= pin_seen_next;
                is_down_reg    <= is_down_next;
                down_start_reg <= down_start_next;
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    last_tap_reg[i]  <= last_tap_next[i];
                    tap_count_reg[i] <= tap_count_next[i];
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

`ifndef ASSERT_OFF
    a_down_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.down_event |->
            out_data_reg.x_taps == '0 && out_data_reg.y_taps == '0 &&
            out_data_reg.z_taps == '0)
        else $error("Down event reported together with tap counts.");

    a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_data_reg.x_taps <= 4'd10 && out_data_reg.y_taps <= 3'd4 &&
            out_data_reg.z_taps <= 2'd2)
        else $error("Reported tap count out of range.");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && out_valid_reg && !out_ready)
        else $error("Input stalled while the pipeline could move.");

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("Evaluated poll did not reach the result register.");

    a_pin_state_frozen_on_down: assert property (@(posedge clk) disable iff (!rst_n)
        advance && fire |=> pin_seen_reg == $past(pin_seen_reg))
        else $error("Pin state changed on a down event.");
`endif

endmodule
